// File: rtl/stc_pkg.sv
// Shared types, widths and helper functions for the selection-to-crop block.
`default_nettype none
package stc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int SOURCE_BITS = 14;
    localparam int MINSEL_BITS = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;
    // quotient bits of each divider chain (one cell per bit)
    localparam int NUM_BITS = COORD_BITS + SOURCE_BITS;
    localparam int DEN_BITS = COORD_BITS;
    localparam int DIV_STEPS = NUM_BITS;
    localparam int LANES = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_VIDEO_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIDEO_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_LEFT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_TOP     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_RIGHT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_BOTTOM  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SEL      = 3'd6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] corner_a_x;
        logic signed [COORD_BITS-1:0] corner_a_y;
        logic signed [COORD_BITS-1:0] corner_b_x;
        logic signed [COORD_BITS-1:0] corner_b_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] content_left;
        logic signed [COORD_BITS-1:0] content_top;
        logic signed [COORD_BITS-1:0] content_right;
        logic signed [COORD_BITS-1:0] content_bottom;
        logic signed [COORD_BITS-1:0] clip_left;
        logic signed [COORD_BITS-1:0] clip_top;
        logic signed [COORD_BITS-1:0] clip_right;
        logic signed [COORD_BITS-1:0] clip_bottom;
        logic [SOURCE_BITS-1:0]       crop_x;
        logic [SOURCE_BITS-1:0]       crop_y;
        logic [SOURCE_BITS-1:0]       crop_width;
        logic [SOURCE_BITS-1:0]       crop_height;
    } t_out;

    // one lane of a restoring divider between two cells
    typedef struct packed {
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] rem;
        logic [DEN_BITS-1:0] den;
        logic [NUM_BITS-1:0] quo;
    } t_div;

    // per-item side data that travels along the pipeline
    typedef struct packed {
        t_in                          corner;
        logic                         ok;
        logic                         horiz;
        logic [COORD_BITS-1:0]        vw;
        logic [COORD_BITS-1:0]        vh;
        logic [NUM_BITS-1:0]          p1;
        logic [NUM_BITS-1:0]          p2;
        logic [COORD_BITS-1:0]        dw;
        logic [COORD_BITS-1:0]        dh;
        logic signed [COORD_BITS-1:0] cl;
        logic signed [COORD_BITS-1:0] ct;
        logic signed [COORD_BITS-1:0] cr;
        logic signed [COORD_BITS-1:0] cb;
        logic                         cok;
        logic signed [COORD_BITS-1:0] sl;
        logic signed [COORD_BITS-1:0] st;
        logic signed [COORD_BITS-1:0] sr;
        logic signed [COORD_BITS-1:0] sb;
        logic                         selok;
        logic                         big;
        logic [COORD_BITS-1:0]        w;
        logic [COORD_BITS-1:0]        h;
        logic                         zx1;
        logic                         zy1;
    } t_side;

    // saturate a two-bit-wider signed value to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [COORD_BITS+1:0] v
    );
        logic signed [COORD_BITS+1:0] hi;
        logic signed [COORD_BITS+1:0] lo;
        hi = (COORD_BITS+2)'(2**(COORD_BITS-1) - 1);
        lo = -(COORD_BITS+2)'(2**(COORD_BITS-1));
        if (v > hi) begin
            return hi[COORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    // widen [lo,hi) to even boundaries unless the range would become empty
    function automatic logic [2*SOURCE_BITS-1:0] align_even(
        input logic [SOURCE_BITS-1:0] lo,
        input logic [SOURCE_BITS-1:0] hi,
        input logic [SOURCE_BITS-1:0] limit
    );
        logic [SOURCE_BITS-1:0] es;
        logic [SOURCE_BITS:0]   up;
        logic [SOURCE_BITS-1:0] ee;
        logic [SOURCE_BITS-1:0] lim_e;
        es = {lo[SOURCE_BITS-1:1], 1'b0};
        up = {1'b0, hi} + (SOURCE_BITS+1)'(1);
        lim_e = {limit[SOURCE_BITS-1:1], 1'b0};
        if ({up[SOURCE_BITS:1], 1'b0} < {1'b0, lim_e}) begin
            ee = {up[SOURCE_BITS-1:1], 1'b0};
        end else begin
            ee = lim_e;
        end
        if (hi <= lo || limit < SOURCE_BITS'(2) || ee <= es) begin
            return {lo, hi};
        end
        return {es, ee};
    endfunction

endpackage
`default_nettype wire

// File: rtl/selection_to_source_crop_core.sv
// Top level: config registers, fit and map pipeline with a fit divider chain and four map lanes.
//
//  channel | direction | handshake         | word
//  in      | input     | i_valid / o_stall | stc_pkg::t_in
//  out     | output    | o_valid / i_stall | stc_pkg::t_out
//  cfg     | input     | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// One word enters per cycle while o_stall is low; each result passes the front
// stages, the fit and map chains of one-bit divider cells and the output register.
// Reset (synchronous, active low) empties the pipeline and loads register
// defaults. The whole pipeline holds while the output word waits and
// i_stall is high; o_stall is then raised to the input side.
`default_nettype none
module selection_to_source_crop_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire stc_pkg::t_in                       i_in,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output stc_pkg::t_out                           o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [stc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [stc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CB = stc_pkg::COORD_BITS;
    localparam int SB = stc_pkg::SOURCE_BITS;
    localparam int NB = stc_pkg::NUM_BITS;
    localparam int DB = stc_pkg::DEN_BITS;
    localparam int NS = stc_pkg::DIV_STEPS;
    localparam int NL = stc_pkg::LANES;

    // configuration
    logic [SB-1:0]          r_vid_w;
    logic [SB-1:0]          r_vid_h;
    logic signed [CB-1:0]   r_view_l;
    logic signed [CB-1:0]   r_view_t;
    logic signed [CB-1:0]   r_view_r;
    logic signed [CB-1:0]   r_view_b;
    logic [stc_pkg::MINSEL_BITS-1:0] r_min_sel;

    logic adv;

    // front stages
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    stc_pkg::t_side r_s0, r_s1, r_s2, r_s3, r_s4, r_s5, r_s6;
    stc_pkg::t_side n_s0, n_s1, n_s3, n_s4, n_s5, n_s6;
    stc_pkg::t_div  r_fit_in, n_fit_in;
    stc_pkg::t_div  r_map_in [NL];
    stc_pkg::t_div  n_map_in [NL];

    // divider chains and their side shift lines
    stc_pkg::t_div  fit_q [NS];
    stc_pkg::t_div  map_q [NL][NS];
    stc_pkg::t_side r_side_a [NS];
    stc_pkg::t_side r_side_b [NS];
    logic [NS-1:0]  r_va;
    logic [NS-1:0]  r_vb;

    stc_pkg::t_out  r_out, n_out;
    logic           r_out_v;

    // front-stage temporaries
    logic signed [CB:0]   dx, dy;
    logic [NB-1:0]        q1;
    logic [CB-1:0]        half_w, half_h;
    logic signed [CB-1:0] min_x, min_y, max_x, max_y;
    logic signed [CB:0]   ex, ey;
    logic [stc_pkg::MINSEL_BITS-1:0] need;
    logic [NB-1:0]        mx0, my0, mx1, my1;
    logic [NB-1:0]        qx0, qy0, qx1, qy1;
    logic [SB-1:0]        x0, y0, x1, y1;
    logic [2*SB-1:0]      ax, ay;
    logic                 crop_ok;

    assign adv = !(r_out_v && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_out_v;
    assign o_out = r_out;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vid_w <= '0;
            r_vid_h <= '0;
            r_view_l <= '0;
            r_view_t <= '0;
            r_view_r <= '0;
            r_view_b <= '0;
            r_min_sel <= stc_pkg::MINSEL_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stc_pkg::REG_VIDEO_WIDTH:  r_vid_w <= i_cfg_data[SB-1:0];
                stc_pkg::REG_VIDEO_HEIGHT: r_vid_h <= i_cfg_data[SB-1:0];
                stc_pkg::REG_VIEW_LEFT:    r_view_l <= i_cfg_data[CB-1:0];
                stc_pkg::REG_VIEW_TOP:     r_view_t <= i_cfg_data[CB-1:0];
                stc_pkg::REG_VIEW_RIGHT:   r_view_r <= i_cfg_data[CB-1:0];
                stc_pkg::REG_VIEW_BOTTOM:  r_view_b <= i_cfg_data[CB-1:0];
                stc_pkg::REG_MIN_SEL:
                    r_min_sel <= i_cfg_data[stc_pkg::MINSEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // capture the incoming word
    always_comb begin
        n_s0 = '0;
        n_s0.corner = i_in;
    end

    // viewport size and the two cross products
    always_comb begin
        n_s1 = r_s0;
        dx = {r_view_r[CB-1], r_view_r} - {r_view_l[CB-1], r_view_l};
        dy = {r_view_b[CB-1], r_view_b} - {r_view_t[CB-1], r_view_t};
        n_s1.vw = (dx > 0) ? dx[CB-1:0] : '0;
        n_s1.vh = (dy > 0) ? dy[CB-1:0] : '0;
        n_s1.ok = (r_vid_w != '0) && (r_vid_h != '0) && (dx > 0) && (dy > 0);
        n_s1.p1 = NB'(n_s1.vw) * NB'(r_vid_h);
        n_s1.p2 = NB'(n_s1.vh) * NB'(r_vid_w);
        n_s1.horiz = (n_s1.p1 <= n_s1.p2);
    end

    // choose the free side and set up the rounding division
    always_comb begin
        n_fit_in.rem = '0;
        n_fit_in.quo = '0;
        if (r_s1.p1 <= r_s1.p2) begin
            n_fit_in.num = r_s1.p1 + NB'(r_vid_w >> 1);
            n_fit_in.den = DB'(r_vid_w);
        end else begin
            n_fit_in.num = r_s1.p2 + NB'(r_vid_h >> 1);
            n_fit_in.den = DB'(r_vid_h);
        end
    end

    // fitted size and centered top-left corner
    always_comb begin
        n_s3 = r_side_a[NS-1];
        q1 = (fit_q[NS-1].quo == '0) ? NB'(1) : fit_q[NS-1].quo;
        if (n_s3.horiz) begin
            n_s3.dw = n_s3.vw;
            n_s3.dh = (q1 < NB'(n_s3.vh)) ? q1[CB-1:0] : n_s3.vh;
        end else begin
            n_s3.dh = n_s3.vh;
            n_s3.dw = (q1 < NB'(n_s3.vw)) ? q1[CB-1:0] : n_s3.vw;
        end
        half_w = (n_s3.vw - n_s3.dw) >> 1;
        half_h = (n_s3.vh - n_s3.dh) >> 1;
        n_s3.cl = stc_pkg::sat_coord((CB+2)'(r_view_l) + $signed({2'b00, half_w}));
        n_s3.ct = stc_pkg::sat_coord((CB+2)'(r_view_t) + $signed({2'b00, half_h}));
    end

    // far edges of the content rectangle
    always_comb begin
        n_s4 = r_s3;
        n_s4.cr = stc_pkg::sat_coord((CB+2)'(r_s3.cl) + $signed({2'b00, r_s3.dw}));
        n_s4.cb = stc_pkg::sat_coord((CB+2)'(r_s3.ct) + $signed({2'b00, r_s3.dh}));
        n_s4.cok = r_s3.ok && (n_s4.cr > r_s3.cl) && (n_s4.cb > r_s3.ct);
    end

    // normalize and clip the selection, check the minimum size
    always_comb begin
        n_s5 = r_s4;
        min_x = (r_s4.corner.corner_a_x < r_s4.corner.corner_b_x) ?
                r_s4.corner.corner_a_x : r_s4.corner.corner_b_x;
        max_x = (r_s4.corner.corner_a_x > r_s4.corner.corner_b_x) ?
                r_s4.corner.corner_a_x : r_s4.corner.corner_b_x;
        min_y = (r_s4.corner.corner_a_y < r_s4.corner.corner_b_y) ?
                r_s4.corner.corner_a_y : r_s4.corner.corner_b_y;
        max_y = (r_s4.corner.corner_a_y > r_s4.corner.corner_b_y) ?
                r_s4.corner.corner_a_y : r_s4.corner.corner_b_y;
        n_s5.sl = (min_x > r_s4.cl) ? min_x : r_s4.cl;
        n_s5.st = (min_y > r_s4.ct) ? min_y : r_s4.ct;
        n_s5.sr = (max_x < r_s4.cr) ? max_x : r_s4.cr;
        n_s5.sb = (max_y < r_s4.cb) ? max_y : r_s4.cb;
        n_s5.selok = r_s4.cok && (n_s5.sr > n_s5.sl) && (n_s5.sb > n_s5.st);
        ex = {n_s5.sr[CB-1], n_s5.sr} - {n_s5.sl[CB-1], n_s5.sl};
        ey = {n_s5.sb[CB-1], n_s5.sb} - {n_s5.st[CB-1], n_s5.st};
        need = (r_min_sel == '0) ? stc_pkg::MINSEL_BITS'(1) : r_min_sel;
        n_s5.big = n_s5.selok && (ex >= $signed((CB+1)'(need)))
                   && (ey >= $signed((CB+1)'(need)));
        n_s5.w = r_s4.cr - r_s4.cl;
        n_s5.h = r_s4.cb - r_s4.ct;
    end

    // scale clip offsets to source pixels, set up the mapping divisions
    always_comb begin
        n_s6 = r_s5;
        mx0 = NB'(r_s5.sl - r_s5.cl) * NB'(r_vid_w);
        my0 = NB'(r_s5.st - r_s5.ct) * NB'(r_vid_h);
        mx1 = NB'(r_s5.sr - r_s5.cl) * NB'(r_vid_w);
        my1 = NB'(r_s5.sb - r_s5.ct) * NB'(r_vid_h);
        n_s6.zx1 = (mx1 == '0);
        n_s6.zy1 = (my1 == '0);
        for (int l = 0; l < NL; l++) begin
            n_map_in[l].rem = '0;
            n_map_in[l].quo = '0;
        end
        n_map_in[0].num = mx0;
        n_map_in[0].den = r_s5.w;
        n_map_in[1].num = my0;
        n_map_in[1].den = r_s5.h;
        n_map_in[2].num = mx1 - NB'(!n_s6.zx1);
        n_map_in[2].den = r_s5.w;
        n_map_in[3].num = my1 - NB'(!n_s6.zy1);
        n_map_in[3].den = r_s5.h;
    end

    // clamp, align and assemble the result word
    always_comb begin
        stc_pkg::t_side s;
        s = r_side_b[NS-1];
        qx0 = map_q[0][NS-1].quo;
        qy0 = map_q[1][NS-1].quo;
        qx1 = s.zx1 ? '0 : map_q[2][NS-1].quo + NB'(1);
        qy1 = s.zy1 ? '0 : map_q[3][NS-1].quo + NB'(1);
        x0 = (qx0 < NB'(r_vid_w)) ? qx0[SB-1:0] : r_vid_w;
        y0 = (qy0 < NB'(r_vid_h)) ? qy0[SB-1:0] : r_vid_h;
        x1 = (qx1 < NB'(r_vid_w)) ? qx1[SB-1:0] : r_vid_w;
        y1 = (qy1 < NB'(r_vid_h)) ? qy1[SB-1:0] : r_vid_h;
        ax = stc_pkg::align_even(x0, x1, r_vid_w);
        ay = stc_pkg::align_even(y0, y1, r_vid_h);
        crop_ok = s.big && (ax[SB-1:0] > ax[2*SB-1:SB]) && (ay[SB-1:0] > ay[2*SB-1:SB]);
        n_out = '0;
        if (s.ok) begin
            n_out.content_left = s.cl;
            n_out.content_top = s.ct;
            n_out.content_right = s.cr;
            n_out.content_bottom = s.cb;
        end
        if (s.selok) begin
            n_out.clip_left = s.sl;
            n_out.clip_top = s.st;
            n_out.clip_right = s.sr;
            n_out.clip_bottom = s.sb;
        end
        if (crop_ok) begin
            n_out.crop_x = ax[2*SB-1:SB];
            n_out.crop_y = ay[2*SB-1:SB];
            n_out.crop_width = ax[SB-1:0] - ax[2*SB-1:SB];
            n_out.crop_height = ay[SB-1:0] - ay[2*SB-1:SB];
        end
    end

    // divider cell chains
    genvar gi, gl;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_fit
            stc_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_d   ((gi == 0) ? r_fit_in : fit_q[(gi == 0) ? 0 : gi-1]),
                .o_d   (fit_q[gi])
            );
        end
        for (gl = 0; gl < NL; gl++) begin : g_lane
            for (gi = 0; gi < NS; gi++) begin : g_map
                stc_div_cell u_cell (
                    .i_clk (i_clk),
                    .i_en  (adv),
                    .i_d   ((gi == 0) ? r_map_in[gl] : map_q[gl][(gi == 0) ? 0 : gi-1]),
                    .o_d   (map_q[gl][gi])
                );
            end
        end
    endgenerate

    // advance payload through all stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_fit_in <= n_fit_in;
            r_side_a[0] <= r_s2;
            for (int k = 1; k < NS; k++) begin
                r_side_a[k] <= r_side_a[k-1];
                r_side_b[k] <= r_side_b[k-1];
            end
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_map_in <= n_map_in;
            r_side_b[0] <= r_s6;
            r_out <= n_out;
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_va <= '0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_vb <= '0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_va <= {r_va[NS-2:0], r_v2};
            r_v3 <= r_va[NS-1];
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_vb <= {r_vb[NS-2:0], r_v6};
            r_out_v <= r_vb[NS-1];
        end
    end

endmodule
`default_nettype wire

// File: rtl/stc_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on the lane.
`default_nettype none
module stc_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire stc_pkg::t_div i_d,
    output stc_pkg::t_div      o_d
);

    stc_pkg::t_div r_d;
    stc_pkg::t_div n_d;
    logic [stc_pkg::DEN_BITS:0] rem2;
    logic [stc_pkg::DEN_BITS:0] diff;
    logic                       ge;

    // shift in the next numerator bit, subtract the divisor where it fits
    always_comb begin
        rem2 = {i_d.rem, i_d.num[stc_pkg::NUM_BITS-1]};
        diff = rem2 - {1'b0, i_d.den};
        ge = rem2 >= {1'b0, i_d.den};
        n_d.den = i_d.den;
        n_d.num = {i_d.num[stc_pkg::NUM_BITS-2:0], 1'b0};
        n_d.quo = {i_d.quo[stc_pkg::NUM_BITS-2:0], ge};
        n_d.rem = ge ? diff[stc_pkg::DEN_BITS-1:0] : rem2[stc_pkg::DEN_BITS-1:0];
    end

    // advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

// File: sim/selection_to_source_crop_core_tb.sv
// Self-checking testbench for the selection-to-source-crop core.
`default_nettype none
module selection_to_source_crop_core_tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    stc_pkg::t_in i_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    stc_pkg::t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [stc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [stc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    selection_to_source_crop_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the configuration registers
    longint video_w = 0, video_h = 0;
    longint view_l = 0, view_t = 0, view_r = 0, view_b = 0;
    longint min_side = 1;

    stc_pkg::t_in  selections[$];
    stc_pkg::t_out crops_due[$];
    int   errors = 0;
    int   words_in = 0, words_out = 0, crops_seen = 0;
    bit   in_taken = 1'b0;
    bit   quiet = 1'b0;
    bit   hold_done = 1'b0;
    int   send_gap = 0, stall_gap = 0, hold_left = 0, idle_cycles = 0;

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint ceil_div(longint n, longint d);
        if (d == 0 || n == 0) return 0;
        return 1 + (n - 1) / d;
    endfunction

    // widen to even pixel edges unless the range would collapse
    function automatic void snap_even(inout longint lo, inout longint hi, input longint lim);
        longint s, e, es, ee;
        s = lmin(lo, lim);
        e = lmin(hi, lim);
        lo = s;
        hi = e;
        if (e <= s || lim < 2) return;
        es = s & ~64'd1;
        ee = lmin((e + 1) & ~64'd1, lim & ~64'd1);
        if (ee <= es) return;
        lo = es;
        hi = ee;
    endfunction

    // fit the video into the viewport, clip the selection, map it to source pixels
    function automatic stc_pkg::t_out fit_and_crop(stc_pkg::t_in c);
        stc_pkg::t_out r;
        longint ax, ay, bx, by, vw, vh, dw, dh, q, need;
        longint cl, ct, cr, cb, sl, st, sr, sb, w, h, x0, y0, x1, y1;
        r = '0;
        ax = longint'(c.corner_a_x); ay = longint'(c.corner_a_y);
        bx = longint'(c.corner_b_x); by = longint'(c.corner_b_y);
        vw = view_r > view_l ? view_r - view_l : 0;
        vh = view_b > view_t ? view_b - view_t : 0;
        if (video_w == 0 || video_h == 0 || vw <= 0 || vh <= 0) return r;
        dw = vw;
        dh = vh;
        if (vw * video_h <= vh * video_w) begin
            q = (video_h * vw + video_w / 2) / video_w;
            dh = lmin(lmax(q, 1), vh);
        end else begin
            q = (video_w * vh + video_h / 2) / video_h;
            dw = lmin(lmax(q, 1), vw);
        end
        cl = sat16(view_l + (vw - dw) / 2);
        ct = sat16(view_t + (vh - dh) / 2);
        cr = sat16(cl + dw);
        cb = sat16(ct + dh);
        r.content_left = 16'(cl); r.content_top = 16'(ct);
        r.content_right = 16'(cr); r.content_bottom = 16'(cb);
        if (cr <= cl || cb <= ct) return r;
        sl = lmax(lmin(ax, bx), cl);
        st = lmax(lmin(ay, by), ct);
        sr = lmin(lmax(ax, bx), cr);
        sb = lmin(lmax(ay, by), cb);
        if (sr <= sl || sb <= st) return r;
        r.clip_left = 16'(sl); r.clip_top = 16'(st);
        r.clip_right = 16'(sr); r.clip_bottom = 16'(sb);
        need = min_side < 1 ? 1 : min_side;
        if (sr - sl < need || sb - st < need) return r;
        w = cr - cl;
        h = cb - ct;
        x0 = lmin((sl - cl) * video_w / w, video_w);
        y0 = lmin((st - ct) * video_h / h, video_h);
        x1 = lmin(ceil_div((sr - cl) * video_w, w), video_w);
        y1 = lmin(ceil_div((sb - ct) * video_h, h), video_h);
        snap_even(x0, x1, video_w);
        snap_even(y0, y1, video_h);
        if (x1 > x0 && y1 > y0) begin
            r.crop_x = 14'(x0); r.crop_y = 14'(y0);
            r.crop_width = 14'(x1 - x0); r.crop_height = 14'(y1 - y0);
        end
        return r;
    endfunction

    // mostly zero, some short, a few long
    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // clock: count accepted words, predict on input, compare on output
    always @(posedge i_clk) begin
        stc_pkg::t_out want;
        in_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles > IDLE_LIMIT) begin
                $display("selection_to_source_crop_core test failed");
                $finish;
            end
            if (i_valid && !o_stall) begin
                crops_due.push_back(fit_and_crop(i_in));
                words_in++;
            end
            if (o_valid && !i_stall) begin
                words_out++;
                if (o_out.crop_width != 0) crops_seen++;
                if (crops_due.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = crops_due.pop_front();
                    check_field("content_left", longint'(want.content_left),
                                longint'(o_out.content_left));
                    check_field("content_top", longint'(want.content_top),
                                longint'(o_out.content_top));
                    check_field("content_right", longint'(want.content_right),
                                longint'(o_out.content_right));
                    check_field("content_bottom", longint'(want.content_bottom),
                                longint'(o_out.content_bottom));
                    check_field("clip_left", longint'(want.clip_left),
                                longint'(o_out.clip_left));
                    check_field("clip_top", longint'(want.clip_top),
                                longint'(o_out.clip_top));
                    check_field("clip_right", longint'(want.clip_right),
                                longint'(o_out.clip_right));
                    check_field("clip_bottom", longint'(want.clip_bottom),
                                longint'(o_out.clip_bottom));
                    check_field("crop_x", longint'(want.crop_x),
                                longint'(o_out.crop_x));
                    check_field("crop_y", longint'(want.crop_y),
                                longint'(o_out.crop_y));
                    check_field("crop_width", longint'(want.crop_width),
                                longint'(o_out.crop_width));
                    check_field("crop_height", longint'(want.crop_height),
                                longint'(o_out.crop_height));
                end
            end
        end
    end

    // sender: advance to the next selection once the current word is taken
    always @(negedge i_clk) begin
        logic nv;
        stc_pkg::t_in nd;
        nv = i_valid;
        nd = i_in;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                nv = 1'b0;
            end else if (selections.size() > 0) begin
                nd = selections.pop_front();
                nv = 1'b1;
                send_gap = pick_gap();
            end else begin
                nv = 1'b0;
            end
        end
        i_valid <= nv;
        i_in <= nd;
    end

    // receiver: random stalls plus one long hold to back up the pipeline
    always @(negedge i_clk) begin
        logic ns;
        if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
        end else if (!hold_done && words_in >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            ns = 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap--;
            ns = 1'b1;
        end else begin
            ns = 1'b0;
            if ($urandom_range(0, 7) == 0) stall_gap = pick_gap();
        end
        i_stall <= ns;
    end

    task automatic cfg_write(logic [stc_pkg::CFG_IDX_BITS-1:0] idx, longint value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(value);
        case (idx)
            stc_pkg::REG_VIDEO_WIDTH:  video_w = value & 16'h3fff;
            stc_pkg::REG_VIDEO_HEIGHT: video_h = value & 16'h3fff;
            stc_pkg::REG_VIEW_LEFT:    view_l = longint'($signed(16'(value)));
            stc_pkg::REG_VIEW_TOP:     view_t = longint'($signed(16'(value)));
            stc_pkg::REG_VIEW_RIGHT:   view_r = longint'($signed(16'(value)));
            stc_pkg::REG_VIEW_BOTTOM:  view_b = longint'($signed(16'(value)));
            stc_pkg::REG_MIN_SEL:      min_side = value & 16'h0fff;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(longint vw, longint vh, longint l, longint t,
                           longint r, longint b, longint m);
        cfg_write(stc_pkg::REG_VIDEO_WIDTH, vw);
        cfg_write(stc_pkg::REG_VIDEO_HEIGHT, vh);
        cfg_write(stc_pkg::REG_VIEW_LEFT, l);
        cfg_write(stc_pkg::REG_VIEW_TOP, t);
        cfg_write(stc_pkg::REG_VIEW_RIGHT, r);
        cfg_write(stc_pkg::REG_VIEW_BOTTOM, b);
        cfg_write(stc_pkg::REG_MIN_SEL, m);
    endtask

    function automatic stc_pkg::t_in corners(longint ax, longint ay, longint bx, longint by);
        stc_pkg::t_in c;
        c.corner_a_x = 16'(ax); c.corner_a_y = 16'(ay);
        c.corner_b_x = 16'(bx); c.corner_b_y = 16'(by);
        return c;
    endfunction

    function automatic longint near(longint lo, longint hi);
        longint span;
        span = lmin(hi - lo, 4000);
        if (span < 0) span = 0;
        return sat16(lo - 20 + longint'($urandom_range(0, 32'(span + 40))));
    endfunction

    // random drags, mostly over the viewport, some anywhere
    task automatic queue_random(int n);
        repeat (n) begin
            if ($urandom_range(0, 9) < 8) begin
                selections.push_back(corners(near(view_l, view_r), near(view_t, view_b),
                                             near(view_l, view_r), near(view_t, view_b)));
            end else begin
                selections.push_back(stc_pkg::t_in'({$urandom, $urandom}));
            end
        end
    endtask

    task automatic drain();
        while (selections.size() > 0 || i_valid || crops_due.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        longint l, t, vwid, vhgt, rr, bb, ms;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: no video, every field zero
        queue_random(10);
        drain();

        // landscape video in a 4:3 viewport, hand-picked drags
        set_all(1920, 1080, 0, 0, 800, 600, 4);
        selections.push_back(corners(0, 0, 800, 600));
        selections.push_back(corners(800, 600, 0, 0));
        selections.push_back(corners(-32768, -32768, 32767, 32767));
        selections.push_back(corners(32767, 32767, -32768, -32768));
        selections.push_back(corners(10, 10, 300, 50));
        selections.push_back(corners(100, 100, 102, 300));
        selections.push_back(corners(100, 100, 104, 104));
        selections.push_back(corners(100, 100, 100, 300));
        selections.push_back(corners(1, 76, 3, 79));
        selections.push_back(corners(399, 299, 401, 301));
        selections.push_back(corners(799, 524, 795, 520));
        selections.push_back(corners(0, 500, 800, 560));
        queue_random(150);
        drain();

        // one-pixel-wide video over the full coordinate range
        quiet = 1'b1;
        set_all(1, 16383, -32768, -32768, 32767, 32767, 0);
        selections.push_back(corners(-32768, -32768, 32767, 32767));
        selections.push_back(corners(-5, -100, 5, 100));
        queue_random(100);
        drain();
        quiet = 1'b0;

        // largest video, largest minimum size
        set_all(16383, 16383, -1000, -2000, 20000, 30000, 4095);
        selections.push_back(corners(-32768, -32768, 32767, 32767));
        queue_random(60);
        drain();

        // empty viewport: right edge left of the left edge
        set_all(640, 480, 500, 0, 100, 400, 1);
        queue_random(20);
        drain();

        // random settings
        for (int p = 0; p < 7; p++) begin
            quiet = (p % 3 == 2);
            l = longint'($signed(16'($urandom)));
            t = longint'($signed(16'($urandom)));
            if (p % 2 == 0) begin
                l = sat16(l / 4);
                t = sat16(t / 4);
            end
            vwid = longint'(p == 3 ? $urandom_range(1, 8) : $urandom_range(1, 16383));
            vhgt = longint'(p == 5 ? $urandom_range(1, 8) : $urandom_range(1, 16383));
            if (p == 6) begin
                rr = longint'($signed(16'($urandom)));
            end else begin
                rr = sat16(l + longint'($urandom_range(1, 3000)));
            end
            bb = sat16(t + longint'($urandom_range(1, 3000)));
            ms = longint'(p == 4 ? $urandom_range(0, 4095) : $urandom_range(0, 40));
            set_all(vwid, vhgt, l, t, rr, bb, ms);
            queue_random(130);
            drain();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d result words for %0d selections over 12 register settings;",
                 words_out, words_in);
        $display("%0d carried a non-empty crop, with one long output hold.", crops_seen);
        if (errors == 0 && crops_due.size() == 0) begin
            $display("selection_to_source_crop_core test passed");
        end else begin
            if (crops_due.size() != 0) $error("%0d results never arrived", crops_due.size());
            $display("selection_to_source_crop_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
rtl/stc_pkg.sv
rtl/stc_div_cell.sv
rtl/selection_to_source_crop_core.sv
sim/selection_to_source_crop_core_tb.sv
